/* rtl/ssedd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssedd_pkg
// Shared widths, reset values and register indexes for the split-sign
// dual moving average dominance detector.
// ----------------------------------------------------------------------------
package ssedd_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int LEVEL_W     = 32;
  localparam int NET_W       = 33;
  localparam int COUNT_OUT_W = 32;

  localparam int ALPHA_W     = 17;
  localparam int THRESH_W    = 31;
  localparam int WARMUP_W    = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 31;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 17'd6554;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 31'd32768;
  localparam logic [WARMUP_W-1:0] WARMUP_RESET = 16'd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ALPHA_POS = 2'd0,
    REG_ALPHA_NEG = 2'd1,
    REG_THRESHOLD = 2'd2,
    REG_WARMUP    = 2'd3
  } cfg_reg_t;

endpackage

/* rtl/ssedd_avg_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssedd_avg_step
// One moving average update: avg + floor(alpha * (target - avg) / 2^F).
// A decay is the same update toward a target of zero.
// ----------------------------------------------------------------------------
module ssedd_avg_step
  import ssedd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic [LEVEL_W-1:0]   avg,
  input  logic [LEVEL_W-1:0]   target,
  input  logic [FRAC_BITS:0]   alpha,
  output logic [LEVEL_W-1:0]   next_avg
);

  localparam int PROD_W = FRAC_BITS + 2 + LEVEL_W + 1;

  logic signed [LEVEL_W:0]     diff;
  logic signed [FRAC_BITS+1:0] alpha_s;
  logic signed [PROD_W-1:0]    prod;
  logic signed [PROD_W-1:0]    step;

  assign diff     = $signed({1'b0, target}) - $signed({1'b0, avg});
  assign alpha_s  = $signed({1'b0, alpha});
  assign prod     = alpha_s * diff;
  assign step     = prod >>> FRAC_BITS;
  assign next_avg = avg + step[LEVEL_W-1:0];

endmodule

/* rtl/split_sign_ema_dominance_detector_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_sign_ema_dominance_detector_top
// Split-sign dual moving average with threshold dominance detection.
//
// Usage:
//   Sample channel (sample_valid/sample_ready, bias_sample) carries one signed
//   Q16.16 request per cycle while sample_ready is high. Result channel
//   (result_valid/result_ready) returns one result per sample: both averages,
//   net, dominance flags, rising-edge events and saturating counters.
//   A sample passes through the input register and then the result register.
//   One sample per cycle is taken while the receiver accepts results; the
//   average update (one multiply and add per side) is combinational.
//   A stalled receiver holds the result register; one more sample is held
//   in the input register, then sample_ready drops.
//   Reset empties both registers, clears the averages, flags and counters and
//   loads the register defaults. The user must write registers via cfg_write/
//   cfg_index/cfg_data only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module split_sign_ema_dominance_detector_top
  import ssedd_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       sample_valid,
  output logic                       sample_ready,
  input  logic signed [SAMPLE_W-1:0] bias_sample,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [LEVEL_W-1:0]         positive_level,
  output logic [LEVEL_W-1:0]         negative_level,
  output logic signed [NET_W-1:0]    net_level,
  output logic                       positive_dominant,
  output logic                       negative_dominant,
  output logic                       positive_event,
  output logic                       negative_event,
  output logic [COUNT_OUT_W-1:0]     positive_event_count,
  output logic [COUNT_OUT_W-1:0]     negative_event_count,
  output logic [COUNT_OUT_W-1:0]     record_count
);

  localparam int AW   = FRAC_BITS + 1;
  localparam int CMPW = (ALPHA_W > AW) ? ALPHA_W : AW;
  localparam logic [CMPW-1:0] ONE_Q = CMPW'(1) << FRAC_BITS;

  // configuration
  logic [ALPHA_W-1:0]  pos_gain;
  logic [ALPHA_W-1:0]  neg_gain;
  logic [THRESH_W-1:0] threshold;
  logic [WARMUP_W-1:0] warmup;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_gain  <= ALPHA_RESET;
      neg_gain  <= ALPHA_RESET;
      threshold <= THRESH_RESET;
      warmup    <= WARMUP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ALPHA_POS: pos_gain  <= cfg_data[ALPHA_W-1:0];
        REG_ALPHA_NEG: neg_gain  <= cfg_data[ALPHA_W-1:0];
        REG_THRESHOLD: threshold <= cfg_data[THRESH_W-1:0];
        REG_WARMUP:    warmup    <= cfg_data[WARMUP_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CMPW-1:0] pos_gain_ext;
  logic [CMPW-1:0] neg_gain_ext;
  logic [AW-1:0]   pos_gain_eff;
  logic [AW-1:0]   neg_gain_eff;

  assign pos_gain_ext = CMPW'(pos_gain);
  assign neg_gain_ext = CMPW'(neg_gain);
  assign pos_gain_eff = (pos_gain_ext > ONE_Q) ? AW'(ONE_Q) : AW'(pos_gain_ext);
  assign neg_gain_eff = (neg_gain_ext > ONE_Q) ? AW'(ONE_Q) : AW'(neg_gain_ext);

  // input register
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s1_go;
  logic                advance;

  assign s1_go        = !result_valid || result_ready;
  assign sample_ready = !s1_valid || s1_go;
  assign advance      = s1_valid && s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_ready) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      s1_sample <= bias_sample;
    end
  end

  // running state
  logic [LEVEL_W-1:0]     pos_avg;
  logic [LEVEL_W-1:0]     neg_avg;
  logic                   prev_pos;
  logic                   prev_neg;
  logic [COUNT_WIDTH-1:0] pos_events;
  logic [COUNT_WIDTH-1:0] neg_events;
  logic [COUNT_WIDTH-1:0] seen;

  // update datapath
  logic                   is_neg;
  logic [LEVEL_W-1:0]     magnitude;
  logic [LEVEL_W-1:0]     pos_target;
  logic [LEVEL_W-1:0]     neg_target;
  logic [LEVEL_W-1:0]     pos_avg_next;
  logic [LEVEL_W-1:0]     neg_avg_next;
  logic signed [NET_W-1:0] net_next;
  logic signed [NET_W-1:0] thr_s;
  logic                   active;
  logic                   pos_dom;
  logic                   neg_dom;
  logic                   pos_ev;
  logic                   neg_ev;
  logic [COUNT_WIDTH-1:0] pos_events_next;
  logic [COUNT_WIDTH-1:0] neg_events_next;
  logic [COUNT_WIDTH-1:0] seen_next;

  assign is_neg     = s1_sample[SAMPLE_W-1];
  assign magnitude  = ~s1_sample + LEVEL_W'(1);
  assign pos_target = is_neg ? '0 : s1_sample;
  assign neg_target = is_neg ? magnitude : '0;

  ssedd_avg_step #(.FRAC_BITS(FRAC_BITS)) u_pos_step (
    .avg      (pos_avg),
    .target   (pos_target),
    .alpha    (pos_gain_eff),
    .next_avg (pos_avg_next)
  );

  ssedd_avg_step #(.FRAC_BITS(FRAC_BITS)) u_neg_step (
    .avg      (neg_avg),
    .target   (neg_target),
    .alpha    (neg_gain_eff),
    .next_avg (neg_avg_next)
  );

  assign net_next = $signed({1'b0, pos_avg_next}) - $signed({1'b0, neg_avg_next});
  assign thr_s    = $signed({2'b00, threshold});
  assign active   = ({1'b0, seen} + (COUNT_WIDTH+1)'(1)) >= (COUNT_WIDTH+1)'(warmup);
  assign pos_dom  = active && (net_next > thr_s);
  assign neg_dom  = active && (net_next < -thr_s);
  assign pos_ev   = pos_dom && !prev_pos;
  assign neg_ev   = neg_dom && !prev_neg;

  assign pos_events_next = (pos_ev && pos_events != '1) ? pos_events + 1'b1 : pos_events;
  assign neg_events_next = (neg_ev && neg_events != '1) ? neg_events + 1'b1 : neg_events;
  assign seen_next       = (seen != '1) ? seen + 1'b1 : seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_avg    <= '0;
      neg_avg    <= '0;
      prev_pos   <= 1'b0;
      prev_neg   <= 1'b0;
      pos_events <= '0;
      neg_events <= '0;
      seen       <= '0;
    end else if (advance) begin
      pos_avg    <= pos_avg_next;
      neg_avg    <= neg_avg_next;
      pos_events <= pos_events_next;
      neg_events <= neg_events_next;
      seen       <= seen_next;
      if (active) begin
        prev_pos <= pos_dom;
        prev_neg <= neg_dom;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      positive_level       <= pos_avg_next;
      negative_level       <= neg_avg_next;
      net_level            <= net_next;
      positive_dominant    <= pos_dom;
      negative_dominant    <= neg_dom;
      positive_event       <= pos_ev;
      negative_event       <= neg_ev;
      positive_event_count <= COUNT_OUT_W'(pos_events_next);
      negative_event_count <= COUNT_OUT_W'(neg_events_next);
      record_count         <= COUNT_OUT_W'(seen_next);
    end
  end

endmodule

/* rtl/ssedd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssedd_checker
// Port-level checks for the dominance detector, bound to the top level.
// ----------------------------------------------------------------------------
module ssedd_checker
  import ssedd_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic [LEVEL_W-1:0]         positive_level,
  input logic [LEVEL_W-1:0]         negative_level,
  input logic signed [NET_W-1:0]    net_level,
  input logic                       positive_dominant,
  input logic                       negative_dominant,
  input logic                       positive_event,
  input logic                       negative_event
);

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("stalled result dropped");

  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(positive_dominant && negative_dominant))
    else $error("both sides dominant");

  a_event: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!positive_event || positive_dominant) &&
                     (!negative_event || negative_dominant))
    else $error("event without dominance");

  a_net: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      net_level == ($signed({1'b0, positive_level}) - $signed({1'b0, negative_level})))
    else $error("net level mismatch");

endmodule

bind split_sign_ema_dominance_detector_top ssedd_checker u_ssedd_checker (.*);
